[rtl/smx_pkg.sv]
`timescale 1ns / 1ps
package smx_pkg;

   typedef struct packed {
      logic signed [15:0] score;
      logic               last_in;
   } req_type;

   typedef struct packed {
      logic [16:0] prob;
      logic [5:0]  elem_index;
      logic        last_out;
      logic        overflow;
   } rsp_type;

   localparam int SCORE_W = 16;
   localparam int EXP_W = 17;
   localparam int SUM_W = 23;
   localparam int EXP_BITS = 13;
   localparam logic [31:0] EXP_C0 = 32'd4278222805;
   localparam int FLUSH_LIMIT = 4096;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;

   // shared multiply unit request
   typedef struct packed {
      logic        start;
      logic [32:0] a;
      logic [31:0] b;
   } mul_req_type;

endpackage

[rtl/smx_mul.sv]
`timescale 1ns / 1ps
// Shared rounding multiplier: q = (a*b + 2^31) >> 32, a up to 33 bits.
// Split into a 16x32 low partial product, registered in lo_ff, and a 17x32 high one added at the output.
module smx_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  smx_pkg::mul_req_type req,
   output logic                 done,
   output logic [32:0]          q
);
   logic [1:0]  phase_ff, phase_in;
   logic [32:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [48:0] lo_ff, lo_in;
   logic [48:0] hi_prod;
   logic [65:0] full;

   assign hi_prod = {32'd0, a_ff[32:16]} * {17'd0, b_ff} ;
   assign full = {1'b0, hi_prod, 16'd0} + {17'd0, lo_ff} + 66'd2147483648;

   always_comb begin
      phase_in = {phase_ff[0], req.start};
      a_in = req.start ? req.a : a_ff;
      b_in = req.start ? req.b : b_ff;
      lo_in = phase_ff[0] ? ({33'd0, a_ff[15:0]} * {17'd0, b_ff}) : lo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      lo_ff <= lo_in;
   end

   assign done = phase_ff[1];
   assign q = full[64:32];
endmodule

[rtl/smx_div.sv]
`timescale 1ns / 1ps
// Restoring divider: quot = (num << 16) / den, one quotient bit per cycle.
// done stays high from the end of a division until the next start.
module smx_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] num,
   input  logic [22:0] den,
   output logic        done,
   output logic [16:0] quot
);
   localparam int NB = 33;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] dvd_ff, dvd_in;
   logic [23:0] rem_ff, rem_in;
   logic [23:0] trial;
   logic [23:0] shifted;

   always_comb begin
      shifted = {rem_ff[22:0], dvd_ff[NB-1]};
      trial = shifted - {1'b0, den};
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff && !start;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = 6'(NB);
         dvd_in = {num, 16'd0};
         rem_in = '0;
      end else if (busy_ff) begin
         if (!trial[23]) begin
            rem_in = trial;
         end else begin
            rem_in = shifted;
         end
         dvd_in = {dvd_ff[NB-2:0], ~trial[23]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   // quotient < 2^17 since num <= sum; zero divisor cannot occur
   assign quot = (den == '0) ? 17'd0 : dvd_ff[16:0];
endmodule

[rtl/softmax_normalizer_core.sv]
`timescale 1ns / 1ps
// Load: one element taken per cycle in ST_LOAD; req_stall is high in other states. After the
// last_in element the exp pass runs the shared multiplier over the 13-bit magnitude of
// score minus max: per bit an acc*c product if the bit is set, then c*c, then write-back.
// The divide pass divides each exp by the sum, one quotient bit a cycle, and waits out any
// result stall; input stays stalled until the last result. Synchronous active-high reset
// clears state, counters, max, sum and flags; the memories are undefined until written.
module softmax_normalizer_core #(
   parameter int MAX_LEN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smx_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smx_pkg::rsp_type  rsp_data
);
   localparam int IW = 6;

   typedef enum logic [7:0] {
      ST_LOAD  = 8'b0000_0001,
      ST_RD    = 8'b0000_0010,
      ST_EXP   = 8'b0000_0100,
      ST_MUL   = 8'b0000_1000,
      ST_EXPW  = 8'b0001_0000,
      ST_DRD   = 8'b0010_0000,
      ST_DIV   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic signed [15:0] score_mem [64];
   logic [16:0]        exp_mem [64];
   logic [6:0]  count_ff, count_in;
   logic signed [15:0] max_ff, max_in;
   logic [22:0] sum_ff, sum_in;
   logic        drop_ff, drop_in;
   logic [6:0]  idx_ff, idx_in;
   logic [3:0]  bit_ff, bit_in;
   logic        sqr_ff, sqr_in;
   logic [32:0] acc_ff, acc_in;
   logic [31:0] c_ff, c_in;
   logic [12:0] m_ff, m_in;
   logic        flush_ff, flush_in;
   logic        div_go_ff, div_go_in;
   logic signed [15:0] rd_score_ff;
   logic [16:0] rd_exp_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   smx_pkg::rsp_type rsp_ff, rsp_in;
   smx_pkg::mul_req_type mreq;
   logic        mdone;
   logic [32:0] mq;
   logic        dstart, ddone;
   logic [16:0] dq;
   logic        take, store_ok;
   logic signed [16:0] diff;
   logic [16:0] exp_val;
   logic [33:0] acc_rnd;

   assign req_stall = (state_ff != ST_LOAD);
   assign take = req_valid && !req_stall;
   assign store_ok = (count_ff < 7'(MAX_LEN));
   assign diff = 17'(rd_score_ff) - 17'(max_ff);
   assign acc_rnd = {1'b0, acc_ff} + 34'd32768;
   assign exp_val = flush_ff ? 17'd0 : acc_rnd[32:16];
   assign dstart = div_go_ff;

   smx_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .done(mdone), .q(mq));
   smx_div u_div (.clock(clock), .reset(reset), .start(dstart), .num(rd_exp_ff),
      .den(sum_ff), .done(ddone), .quot(dq));

   // memories
   always_ff @(posedge clock) begin
      if (take && store_ok) begin
         score_mem[count_ff[IW-1:0]] <= req_data.score;
      end
      if (state_ff == ST_EXPW) begin
         exp_mem[idx_ff[IW-1:0]] <= exp_val;
      end
      rd_score_ff <= score_mem[idx_ff[IW-1:0]];
      rd_exp_ff <= exp_mem[idx_ff[IW-1:0]];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      max_in = max_ff;
      sum_in = sum_ff;
      drop_in = drop_ff;
      idx_in = idx_ff;
      bit_in = bit_ff;
      sqr_in = sqr_ff;
      acc_in = acc_ff;
      c_in = c_ff;
      m_in = m_ff;
      flush_in = flush_ff;
      mreq = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      case (state_ff)
         ST_LOAD: begin
            if (take) begin
               if (store_ok) begin
                  if (count_ff == '0 || req_data.score > max_ff) begin
                     max_in = req_data.score;
                  end
                  count_in = count_ff + 7'd1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_data.last_in) begin
                  idx_in = '0;
                  sum_in = '0;
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            // memory read latency
            state_in = ST_EXP;
         end
         ST_EXP: begin
            flush_in = (diff < -17'sd4096);
            m_in = 13'(-diff);
            acc_in = 33'h1_0000_0000;
            c_in = smx_pkg::EXP_C0;
            bit_in = '0;
            sqr_in = 1'b0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // each bit: optional acc*c, then c*c, via the shared multiplier
            if (bit_ff == 4'(smx_pkg::EXP_BITS)) begin
               state_in = ST_EXPW;
            end else if (!sqr_ff && !m_ff[0]) begin
               sqr_in = 1'b1;
            end else begin
               mreq.start = 1'b1;
               mreq.a = sqr_ff ? {1'b0, c_ff} : acc_ff;
               mreq.b = c_ff;
               state_in = ST_EXPW;
            end
         end
         ST_EXPW: begin
            if (bit_ff == 4'(smx_pkg::EXP_BITS)) begin
               // exp value written to memory this cycle
               sum_in = sum_ff + 23'(exp_val);
               if (idx_ff + 7'd1 == count_ff) begin
                  idx_in = '0;
                  state_in = ST_DRD;
               end else begin
                  idx_in = idx_ff + 7'd1;
                  state_in = ST_RD;
               end
            end else if (mdone) begin
               if (sqr_ff) begin
                  c_in = mq[31:0];
                  sqr_in = 1'b0;
                  m_in = m_ff >> 1;
                  bit_in = bit_ff + 4'd1;
               end else begin
                  acc_in = mq;
                  sqr_in = 1'b1;
               end
               state_in = ST_MUL;
            end
         end
         ST_DRD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // done from the previous element is still high on the launch cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               if (ddone && !div_go_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.prob = dq;
                  rsp_in.elem_index = idx_ff[IW-1:0];
                  rsp_in.last_out = (idx_ff + 7'd1 == count_ff);
                  rsp_in.overflow = drop_ff;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (idx_ff + 7'd1 == count_ff) begin
               count_in = '0;
               max_in = smx_pkg::SCORE_MIN;
               sum_in = '0;
               drop_in = 1'b0;
               state_in = ST_LOAD;
            end else begin
               idx_in = idx_ff + 7'd1;
               state_in = ST_DRD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
      // divider launched on entry to ST_DIV, once the exp read data is valid
      div_go_in = (state_ff == ST_DRD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         max_ff <= smx_pkg::SCORE_MIN;
         sum_ff <= '0;
         drop_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff <= '0;
         div_go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         max_ff <= max_in;
         sum_ff <= sum_in;
         drop_ff <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff <= idx_in;
         div_go_ff <= div_go_in;
      end
      bit_ff <= bit_in;
      sqr_ff <= sqr_in;
      acc_ff <= acc_in;
      c_ff <= c_in;
      m_ff <= m_in;
      flush_ff <= flush_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // checks
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !take) else $error("input taken while busy");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 7'(MAX_LEN)) else $error("count above capacity");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_ff)) else $error("result changed");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> rsp_valid_ff) else $error("out without result");
endmodule
